// ===== rtl/dtr_pkg.sv =====
// Shared types, constants and helper functions of the diatonic transpose block.
package dtr_pkg;

    localparam int NUM_DEG  = 12;
    localparam int NOTE_W   = 7;
    localparam int DEG_W    = 4;
    localparam int STEP_W   = 6;
    localparam int MAP_W    = 24;
    localparam int TONIC_W  = 4;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [NOTE_W-1:0] NOTE_MAX     = 7'd127;
    localparam logic [NOTE_W-1:0] OCTAVE_NOTE  = 7'd12;
    localparam logic [NOTE_W-1:0] FOLD_UP_MAX  = 7'd115;
    localparam logic [DEG_W-1:0]  DEG_LAST     = 4'd11;
    localparam logic [DEG_W-1:0]  SNAP_LIMIT   = 4'd12;
    localparam logic [7:0]        TWO_OCTAVES  = 8'd24;

    typedef logic [1:0] t_code;
    localparam t_code CODE_SNAP_UP = 2'd1;

    typedef enum logic [1:0] {
        REG_SCALE_MAP  = 2'd0,
        REG_TONIC      = 2'd1,
        REG_STEP_COUNT = 2'd2
    } t_reg_idx;

    typedef enum logic {
        RES_NOTE = 1'b0,
        RES_MAP  = 1'b1
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     fold;
        logic     deg_load;
        logic     snap;
        logic     tone;
        logic     res_load;
        t_res_sel res_sel;
        logic     push;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic fold_more;
        logic is_tone;
        logic snap_out;
    } t_dp_status;

    // Remainder by twelve of an 8-bit value, via a reciprocal multiply.
    function automatic logic [DEG_W-1:0] mod12(input logic [7:0] v);
        logic [15:0] prod;
        logic [7:0]  quo;
        logic [7:0]  rem;
        prod = {8'd0, v} * 16'd171;
        quo  = {3'd0, prod[15:11]};
        rem  = v - (quo << 3) - (quo << 2);
        return rem[DEG_W-1:0];
    endfunction

    // A degree is a scale tone when both bits of its code agree.
    function automatic logic [NUM_DEG-1:0] tone_mask(input logic [MAP_W-1:0] map);
        logic [NUM_DEG-1:0] m;
        for (int d = 0; d < NUM_DEG; d++) begin
            m[d] = (map[2*d] == map[2*d+1]);
        end
        return m;
    endfunction

    function automatic logic [DEG_W-1:0] popcount12(input logic [NUM_DEG-1:0] m);
        logic [DEG_W-1:0] c;
        c = '0;
        for (int d = 0; d < NUM_DEG; d++) begin
            c = c + {{(DEG_W-1){1'b0}}, m[d]};
        end
        return c;
    endfunction

endpackage

// ===== rtl/dtr_in_if.sv =====
// Input channel carrying one note transaction.
interface dtr_in_if;
    logic                         valid;
    logic                         ready;
    logic [dtr_pkg::NOTE_W-1:0]   note_in;
    logic                         end_of_pattern;

    modport source(output valid, output note_in, output end_of_pattern, input ready);
    modport sink(input valid, input note_in, input end_of_pattern, output ready);
endinterface

// ===== rtl/dtr_out_if.sv =====
// Output channel carrying one transposed note transaction.
interface dtr_out_if;
    logic                         valid;
    logic                         ready;
    logic [dtr_pkg::NOTE_W-1:0]   note_out;
    logic                         end_of_pattern_out;

    modport source(output valid, output note_out, output end_of_pattern_out, input ready);
    modport sink(input valid, input note_out, input end_of_pattern_out, output ready);
endinterface

// ===== rtl/dtr_regs.sv =====
// APB-style configuration registers: scale map, tonic and step count.
module dtr_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dtr_pkg::ADDR_W-1:0]    paddr,
    input  logic [dtr_pkg::DATA_W-1:0]    pwdata,
    output logic [dtr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output logic [dtr_pkg::MAP_W-1:0]     o_scale_map,
    output logic [dtr_pkg::TONIC_W-1:0]   o_tonic,
    output logic [dtr_pkg::STEP_W-1:0]    o_step_count
);

    logic [dtr_pkg::MAP_W-1:0]   r_scale_map;
    logic [dtr_pkg::TONIC_W-1:0] r_tonic;
    logic [dtr_pkg::STEP_W-1:0]  r_step_count;
    logic                        w_write;
    dtr_pkg::t_reg_idx           w_idx;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite;
    assign w_idx   = dtr_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_map  <= '0;
            r_tonic      <= '0;
            r_step_count <= '0;
        end else if (w_write) begin
            case (w_idx)
                dtr_pkg::REG_SCALE_MAP:  r_scale_map  <= pwdata[dtr_pkg::MAP_W-1:0];
                dtr_pkg::REG_TONIC:      r_tonic      <= pwdata[dtr_pkg::TONIC_W-1:0];
                dtr_pkg::REG_STEP_COUNT: r_step_count <= pwdata[dtr_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            dtr_pkg::REG_SCALE_MAP:
                prdata = {{(dtr_pkg::DATA_W-dtr_pkg::MAP_W){1'b0}}, r_scale_map};
            dtr_pkg::REG_TONIC:
                prdata = {{(dtr_pkg::DATA_W-dtr_pkg::TONIC_W){1'b0}}, r_tonic};
            dtr_pkg::REG_STEP_COUNT:
                prdata = {{(dtr_pkg::DATA_W-dtr_pkg::STEP_W){1'b0}}, r_step_count};
            default:
                prdata = '0;
        endcase
    end

    assign o_scale_map  = r_scale_map;
    assign o_tonic      = r_tonic;
    assign o_step_count = r_step_count;

endmodule

// ===== rtl/dtr_ctrl.sv =====
// Sequencer that steps one note through octave fold, snap, remap and output.
module dtr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    input  dtr_pkg::t_dp_status i_status,
    output dtr_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FOLD,
        S_SNAP,
        S_TONE,
        S_APPLY,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FOLD;
                end
            end
            S_FOLD: begin
                if (i_status.empty) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = dtr_pkg::RES_NOTE;
                    n_state        = S_DONE;
                end else if (i_status.fold_more) begin
                    o_cmd.fold = 1'b1;
                end else begin
                    o_cmd.deg_load = 1'b1;
                    n_state        = S_SNAP;
                end
            end
            S_SNAP: begin
                if (i_status.is_tone) begin
                    n_state = S_TONE;
                end else if (i_status.snap_out) begin
                    // The map points in a circle: keep the folded note.
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = dtr_pkg::RES_NOTE;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.snap = 1'b1;
                end
            end
            S_TONE: begin
                o_cmd.tone = 1'b1;
                n_state    = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = dtr_pkg::RES_MAP;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/dtr_dp.sv =====
// Datapath: note, step magnitude, degree and output registers with their update logic.
module dtr_dp (
    input  logic                          i_clk,
    input  logic [dtr_pkg::MAP_W-1:0]     i_scale_map,
    input  logic [dtr_pkg::TONIC_W-1:0]   i_tonic,
    input  logic [dtr_pkg::STEP_W-1:0]    i_step_count,
    input  logic [dtr_pkg::NOTE_W-1:0]    i_note_in,
    input  logic                          i_eop,
    input  dtr_pkg::t_dp_cmd              i_cmd,
    output dtr_pkg::t_dp_status           o_status,
    output logic [dtr_pkg::NOTE_W-1:0]    o_note_out,
    output logic                          o_eop_out
);

    localparam int NOTE_W = dtr_pkg::NOTE_W;
    localparam int DEG_W  = dtr_pkg::DEG_W;
    localparam int STEP_W = dtr_pkg::STEP_W;

    logic [NOTE_W-1:0]  r_note;
    logic               r_eop;
    logic               r_neg;
    logic [STEP_W-1:0]  r_mag;
    logic [DEG_W-1:0]   r_deg;
    logic [DEG_W-1:0]   r_snap_cnt;
    logic [DEG_W-1:0]   r_newtone;
    logic [NOTE_W-1:0]  r_res;
    logic [NOTE_W-1:0]  r_out_note;
    logic               r_out_eop;

    logic [dtr_pkg::NUM_DEG-1:0] w_mask;
    logic [DEG_W-1:0]            w_ndia;
    logic [DEG_W-1:0]            w_rank [dtr_pkg::NUM_DEG];
    dtr_pkg::t_code              w_code;
    logic [STEP_W-1:0]           w_abs;
    logic [NOTE_W-1:0]           w_fold_note;
    logic [DEG_W-1:0]            w_snap_deg;
    logic [7:0]                  w_deg_sum;
    logic signed [5:0]           w_newtone;
    logic [DEG_W-1:0]            w_newdeg;
    logic signed [5:0]           w_chroma;
    logic signed [8:0]           w_sum;
    logic [NOTE_W-1:0]           w_apply;

    assign w_mask = dtr_pkg::tone_mask(i_scale_map);
    assign w_ndia = dtr_pkg::popcount12(w_mask);
    assign w_code = i_scale_map[{r_deg, 1'b0} +: 2];

    // Rank of each degree among the scale tones below it.
    always_comb begin
        logic [DEG_W-1:0] cnt;
        cnt = '0;
        for (int d = 0; d < dtr_pkg::NUM_DEG; d++) begin
            w_rank[d] = cnt;
            cnt = cnt + {{(DEG_W-1){1'b0}}, w_mask[d]};
        end
    end

    assign w_abs = i_step_count[STEP_W-1] ? (~i_step_count + 1'b1) : i_step_count;

    // One octave move per fold, clamped to the MIDI range.
    always_comb begin
        if (r_neg) begin
            w_fold_note = (r_note < dtr_pkg::OCTAVE_NOTE) ? '0
                                                          : r_note - dtr_pkg::OCTAVE_NOTE;
        end else begin
            w_fold_note = (r_note > dtr_pkg::FOLD_UP_MAX) ? dtr_pkg::NOTE_MAX
                                                          : r_note + dtr_pkg::OCTAVE_NOTE;
        end
    end

    assign w_deg_sum = {1'b0, r_note} + dtr_pkg::TWO_OCTAVES - {4'd0, i_tonic};

    always_comb begin
        if (w_code == dtr_pkg::CODE_SNAP_UP) begin
            w_snap_deg = (r_deg == dtr_pkg::DEG_LAST) ? '0 : r_deg + 1'b1;
        end else begin
            w_snap_deg = (r_deg == '0) ? dtr_pkg::DEG_LAST : r_deg - 1'b1;
        end
    end

    // New tone index, wrapped once into the scale.
    always_comb begin
        logic signed [5:0] steps;
        logic signed [5:0] raw;
        steps = r_neg ? -$signed({2'b00, r_mag[DEG_W-1:0]})
                      : $signed({2'b00, r_mag[DEG_W-1:0]});
        raw   = $signed({2'b00, w_rank[r_deg]}) + steps;
        if (raw < 0) begin
            w_newtone = raw + $signed({2'b00, w_ndia});
        end else if (raw >= $signed({2'b00, w_ndia})) begin
            w_newtone = raw - $signed({2'b00, w_ndia});
        end else begin
            w_newtone = raw;
        end
    end

    always_comb begin
        w_newdeg = '0;
        for (int d = 0; d < dtr_pkg::NUM_DEG; d++) begin
            if (w_mask[d] && (w_rank[d] == r_newtone)) begin
                w_newdeg = DEG_W'(d);
            end
        end
    end

    always_comb begin
        w_chroma = $signed({2'b00, w_newdeg}) - $signed({2'b00, r_deg});
        if (!r_neg && (r_mag != '0) && (w_chroma < 0)) begin
            w_chroma = w_chroma + 6'sd12;
        end else if (r_neg && (r_mag != '0) && (w_chroma > 0)) begin
            w_chroma = w_chroma - 6'sd12;
        end
        w_sum = $signed({2'b00, r_note}) + {{3{w_chroma[5]}}, w_chroma};
        if (w_sum > 9'sd127) begin
            w_sum = w_sum - 9'sd12;
        end else if (w_sum < 0) begin
            w_sum = w_sum + 9'sd12;
        end
        w_apply = w_sum[NOTE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_note <= i_note_in;
            r_eop  <= i_eop;
            r_neg  <= i_step_count[STEP_W-1];
            r_mag  <= w_abs;
        end
        if (i_cmd.fold) begin
            r_note <= w_fold_note;
            r_mag  <= r_mag - {2'b00, w_ndia};
        end
        if (i_cmd.deg_load) begin
            r_deg      <= dtr_pkg::mod12(w_deg_sum);
            r_snap_cnt <= '0;
        end
        if (i_cmd.snap) begin
            r_deg      <= w_snap_deg;
            r_snap_cnt <= r_snap_cnt + 1'b1;
        end
        if (i_cmd.tone) begin
            r_newtone <= w_newtone[DEG_W-1:0];
        end
        if (i_cmd.res_load) begin
            r_res <= (i_cmd.res_sel == dtr_pkg::RES_NOTE) ? r_note : w_apply;
        end
        if (i_cmd.push) begin
            r_out_note <= r_res;
            r_out_eop  <= r_eop;
        end
    end

    assign o_status.empty     = (w_ndia == '0);
    assign o_status.fold_more = ({2'b00, w_ndia} <= r_mag);
    assign o_status.is_tone   = w_mask[r_deg];
    assign o_status.snap_out  = (r_snap_cnt == dtr_pkg::SNAP_LIMIT);

    assign o_note_out = r_out_note;
    assign o_eop_out  = r_out_eop;

endmodule

// ===== rtl/diatonic_transpose.sv =====
// Top level of the diatonic transpose block.
// Each note transaction is taken only while the sequencer is idle and is then worked on
// alone: a load, one fold per octave (the octave count is floor(|step_count| / tones in
// the scale), up to 32 with a one-tone scale), snap moves onto a scale tone (up to 12
// moves), tone remapping in the tone and apply states and a hand-over of the result to
// the output register. An empty scale skips the fold, snap and remap steps. A map whose
// snaps run in a circle gives up after 12 moves without remapping. The hand-over waits
// for as long as the output register still holds a result that has not been taken. The
// output register lets the next note be taken while the previous result still waits.
module diatonic_transpose (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dtr_pkg::ADDR_W-1:0]    paddr,
    input  logic [dtr_pkg::DATA_W-1:0]    pwdata,
    output logic [dtr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    dtr_in_if.sink                        i_note_ch,
    dtr_out_if.source                     o_note_ch
);

    logic [dtr_pkg::MAP_W-1:0]   w_scale_map;
    logic [dtr_pkg::TONIC_W-1:0] w_tonic;
    logic [dtr_pkg::STEP_W-1:0]  w_step_count;
    dtr_pkg::t_dp_cmd            w_cmd;
    dtr_pkg::t_dp_status         w_status;

    dtr_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_scale_map  (w_scale_map),
        .o_tonic      (w_tonic),
        .o_step_count (w_step_count)
    );

    dtr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_note_ch.valid),
        .o_in_ready  (i_note_ch.ready),
        .i_out_ready (o_note_ch.ready),
        .o_out_valid (o_note_ch.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    dtr_dp u_dp (
        .i_clk        (i_clk),
        .i_scale_map  (w_scale_map),
        .i_tonic      (w_tonic),
        .i_step_count (w_step_count),
        .i_note_in    (i_note_ch.note_in),
        .i_eop        (i_note_ch.end_of_pattern),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_note_out   (o_note_ch.note_out),
        .o_eop_out    (o_note_ch.end_of_pattern_out)
    );

endmodule

// ===== dv/diatonic_transpose_tb.sv =====
// Self-checking testbench for the diatonic transpose block: directed table, then random phases.
`timescale 1ns / 1ps

module diatonic_transpose_tb;
    import dtr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 64;
    localparam int DIR_ROWS     = 23;
    localparam int PHASES       = 15;
    localparam int PHASE_ITEMS  = 60;
    localparam int HOLD_PHASE   = 5;
    localparam int PAUSE_PHASE  = 8;
    localparam int QUIET_PHASES = 2;

    // Scale map codes, two bits per degree.
    localparam t_code CODE_TONE      = 2'd0;
    localparam t_code CODE_SNAP_DOWN = 2'd2;
    localparam t_code CODE_TONE_ALT  = 2'd3;

    typedef enum int {
        MAP_RAW,
        MAP_SCALE,
        MAP_EMPTY,
        MAP_CHROMATIC,
        MAP_ONE_TONE
    } t_map_style;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic              eop;
    } t_note_res;

    typedef struct packed {
        logic [MAP_W-1:0]   map;
        logic [TONIC_W-1:0] tonic;
        logic [STEP_W-1:0]  step;
        logic [NOTE_W-1:0]  note;
        logic               eop;
        logic               known;
        logic [NOTE_W-1:0]  known_note;
    } t_dir_row;

    // Rows with known set carry an expectation that is plain from the scale alone.
    t_dir_row dir_table [DIR_ROWS] = '{
        '{24'h000000, 4'd0,  6'h00, 7'd0,   1'b0, 1'b1, 7'd0},
        '{24'h000000, 4'd0,  6'h00, 7'd127, 1'b1, 1'b1, 7'd127},
        '{24'h000000, 4'd0,  6'h1F, 7'd127, 1'b0, 1'b0, 7'd0},
        '{24'h000000, 4'd0,  6'h20, 7'd0,   1'b1, 1'b0, 7'd0},
        '{24'h000000, 4'd0,  6'h3F, 7'd0,   1'b0, 1'b0, 7'd0},
        '{24'h000000, 4'd0,  6'h01, 7'd127, 1'b1, 1'b0, 7'd0},
        '{24'hFFFFFF, 4'd0,  6'h3F, 7'd0,   1'b0, 1'b0, 7'd0},
        '{24'hFFFFFF, 4'd0,  6'h01, 7'd127, 1'b1, 1'b0, 7'd0},
        '{24'h111044, 4'd0,  6'h01, 7'd60,  1'b0, 1'b0, 7'd0},
        '{24'h111044, 4'd0,  6'h3F, 7'd61,  1'b0, 1'b0, 7'd0},
        '{24'h111044, 4'd0,  6'h07, 7'd60,  1'b1, 1'b0, 7'd0},
        '{24'h111044, 4'd0,  6'h39, 7'd5,   1'b0, 1'b0, 7'd0},
        '{24'h111044, 4'd11, 6'h18, 7'd100, 1'b0, 1'b0, 7'd0},
        '{24'h111044, 4'd15, 6'h28, 7'd3,   1'b1, 1'b0, 7'd0},
        '{24'h555555, 4'd0,  6'h05, 7'd60,  1'b0, 1'b1, 7'd60},
        '{24'hAAAAAA, 4'd7,  6'h20, 7'd127, 1'b1, 1'b1, 7'd127},
        '{24'h000009, 4'd0,  6'h03, 7'd0,   1'b0, 1'b1, 7'd0},
        '{24'h000009, 4'd0,  6'h03, 7'd12,  1'b1, 1'b1, 7'd12},
        '{24'h000009, 4'd0,  6'h3D, 7'd13,  1'b0, 1'b0, 7'd0},
        '{24'h555554, 4'd0,  6'h1F, 7'd0,   1'b0, 1'b0, 7'd0},
        '{24'h555554, 4'd0,  6'h20, 7'd127, 1'b1, 1'b0, 7'd0},
        '{24'h000002, 4'd0,  6'h02, 7'd0,   1'b0, 1'b0, 7'd0},
        '{24'h400000, 4'd0,  6'h3E, 7'd11,  1'b1, 1'b0, 7'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    dtr_in_if  in_ch ();
    dtr_out_if out_ch ();

    diatonic_transpose dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .i_note_ch (in_ch),
        .o_note_ch (out_ch)
    );

    // Register image used by the predictor.
    logic [MAP_W-1:0]   scale_map_q;
    logic [TONIC_W-1:0] tonic_q;
    logic [STEP_W-1:0]  step_count_q;

    t_note_res pending_notes [$];
    int fail_count   = 0;
    int cycle_count  = 0;
    int rx_hold_left = 0;
    int rx_stall_left = 0;
    bit idle_on      = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [NOTE_W-1:0] transpose_note(input logic [NOTE_W-1:0] note_in);
        logic [NUM_DEG-1:0] tones;
        t_code code;
        int note, s, ntones, mag, steps, deg, k, tone, newtone, newdeg, chroma;
        ntones = 0;
        for (int d = 0; d < NUM_DEG; d++) begin
            code = scale_map_q[2*d +: 2];
            tones[d] = (code == CODE_TONE) || (code == CODE_TONE_ALT);
            if (tones[d]) ntones++;
        end
        if (ntones == 0) return note_in;
        note = note_in;
        s = $signed(step_count_q);
        mag = (s < 0) ? -s : s;
        // Every full scale's worth of steps becomes an octave, clamped at each move.
        while (mag >= ntones) begin
            note += (s > 0) ? 12 : -12;
            if (note < 0) note = 0;
            if (note > 127) note = 127;
            mag -= ntones;
        end
        steps = (s < 0) ? -mag : mag;
        deg = (note + 24 - int'(tonic_q)) % 12;
        for (k = 0; k < NUM_DEG && !tones[deg]; k++) begin
            if (scale_map_q[2*deg +: 2] == CODE_SNAP_UP) deg = (deg + 1) % 12;
            else deg = (deg + 11) % 12;
        end
        // A map whose snaps run in a circle leaves the folded note as it is.
        if (!tones[deg]) return note[NOTE_W-1:0];
        tone = 0;
        for (int d = 0; d < deg; d++) if (tones[d]) tone++;
        newtone = tone + steps;
        if (newtone < 0) newtone += ntones;
        if (newtone >= ntones) newtone -= ntones;
        newdeg = 0;
        k = 0;
        for (int d = 0; d < NUM_DEG; d++) begin
            if (tones[d]) begin
                if (k == newtone) begin
                    newdeg = d;
                    break;
                end
                k++;
            end
        end
        chroma = newdeg - deg;
        if (steps > 0 && chroma < 0) chroma += 12;
        if (steps < 0 && chroma > 0) chroma -= 12;
        note += chroma;
        if (note > 127) note -= 12;
        if (note < 0) note += 12;
        return note[NOTE_W-1:0];
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_note_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_notes.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected transaction: note %0d eop %0d",
                             out_ch.note_out, out_ch.end_of_pattern_out);
                fail_count++;
            end else begin
                want = pending_notes.pop_front();
                if (out_ch.note_out !== want.note || out_ch.end_of_pattern_out !== want.eop) begin
                    if (fail_count < 10)
                        $display("mismatch: expected note %0d eop %0d, got note %0d eop %0d",
                                 want.note, want.eop, out_ch.note_out,
                                 out_ch.end_of_pattern_out);
                    fail_count++;
                end
            end
        end
    end

    // Output back-pressure: a long hold when asked for, otherwise short random stalls.
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            out_ch.ready <= 1'b0;
            rx_hold_left--;
        end else if (rx_stall_left > 0) begin
            out_ch.ready <= 1'b0;
            rx_stall_left--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            out_ch.ready <= 1'b0;
            rx_stall_left = $urandom_range(0, 2);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_note(input logic [NOTE_W-1:0] note, input logic eop,
                             input logic known, input logic [NOTE_W-1:0] known_note);
        t_note_res res;
        in_ch.valid          <= 1'b1;
        in_ch.note_in        <= note;
        in_ch.end_of_pattern <= eop;
        do @(posedge i_clk); while (!in_ch.ready);
        res.note = known ? known_note : transpose_note(note);
        res.eop  = eop;
        pending_notes.push_back(res);
    endtask

    task automatic idle_gap();
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_notes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SCALE_MAP:  scale_map_q  = value[MAP_W-1:0];
            REG_TONIC:      tonic_q      = value[TONIC_W-1:0];
            REG_STEP_COUNT: step_count_q = value[STEP_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Registers change only once the block has handed back every transaction.
    task automatic load_scale(input logic [MAP_W-1:0] map, input logic [TONIC_W-1:0] tonic,
                              input logic [STEP_W-1:0] step);
        drain();
        apb_write(REG_SCALE_MAP, DATA_W'(map));
        apb_write(REG_TONIC, DATA_W'(tonic));
        apb_write(REG_STEP_COUNT, DATA_W'(step));
    endtask

    function automatic logic [MAP_W-1:0] random_map(input t_map_style style);
        logic [MAP_W-1:0] map;
        int one;
        map = MAP_W'($urandom());
        one = $urandom_range(0, NUM_DEG - 1);
        for (int d = 0; d < NUM_DEG; d++) begin
            case (style)
                MAP_SCALE:
                    if ($urandom_range(0, 2) == 0)
                        map[2*d +: 2] = $urandom_range(0, 1) ? CODE_SNAP_UP : CODE_SNAP_DOWN;
                    else
                        map[2*d +: 2] = ($urandom_range(0, 7) == 0) ? CODE_TONE_ALT : CODE_TONE;
                MAP_EMPTY:
                    map[2*d +: 2] = $urandom_range(0, 1) ? CODE_SNAP_UP : CODE_SNAP_DOWN;
                MAP_CHROMATIC:
                    map[2*d +: 2] = $urandom_range(0, 1) ? CODE_TONE : CODE_TONE_ALT;
                MAP_ONE_TONE:
                    if (d == one) map[2*d +: 2] = CODE_TONE;
                    else map[2*d +: 2] = ($urandom_range(0, 3) == 0) ? CODE_SNAP_DOWN
                                                                      : CODE_SNAP_UP;
                default: ;
            endcase
        end
        return map;
    endfunction

    initial begin
        logic [MAP_W-1:0]   map;
        logic [TONIC_W-1:0] tonic;
        logic [STEP_W-1:0]  step;
        logic [NOTE_W-1:0]  note;
        in_ch.valid          = 1'b0;
        in_ch.note_in        = '0;
        in_ch.end_of_pattern = 1'b0;
        out_ch.ready         = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        scale_map_q  = '0;
        tonic_q      = '0;
        step_count_q = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].map != scale_map_q || dir_table[r].tonic != tonic_q ||
                dir_table[r].step != step_count_q)
                load_scale(dir_table[r].map, dir_table[r].tonic, dir_table[r].step);
            send_note(dir_table[r].note, dir_table[r].eop, dir_table[r].known,
                      dir_table[r].known_note);
        end

        for (int p = 0; p < PHASES; p++) begin
            map = random_map(t_map_style'($urandom_range(0, 4)));
            if (p == 0) begin
                tonic = 4'd15;
                step  = 6'h1F;
            end else if (p == 1) begin
                tonic = 4'd0;
                step  = 6'h20;
            end else begin
                tonic = $urandom_range(0, 15);
                if ($urandom_range(0, 3) == 0) step = $urandom_range(0, 63);
                else step = STEP_W'($urandom_range(0, 48) - 24);
            end
            load_scale(map, tonic, step);
            idle_on = (p < PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
            // Hold the output back so the block fills and refuses new notes.
            if (p == HOLD_PHASE) rx_hold_left = 300;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 9) == 0) note = $urandom_range(0, 1) ? NOTE_MAX : '0;
                else note = $urandom_range(0, 127);
                send_note(note, 1'($urandom_range(0, 1)), 1'b0, '0);
                if (p == PAUSE_PHASE && i == PHASE_ITEMS / 2)
                    drain();
                else if (idle_on && p != HOLD_PHASE && $urandom_range(0, 4) == 0)
                    idle_gap();
            end
        end

        drain();
        if (fail_count == 0 && pending_notes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
